### hw/rtl/nhb_pkg.sv
`default_nettype none

package nhb_pkg;

   // Field layout of one received status byte.
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned SLOT_W    = 2;
   localparam int unsigned NIBBLE_W  = 4;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned SLOT_CNT  = 4;

   localparam int unsigned MODE_LSB  = 6;
   localparam int unsigned SLOT_LSB  = 4;

   localparam logic [SLOT_W-1:0] FIRST_SLOT = 2'd0;
   localparam logic [SLOT_W-1:0] LAST_SLOT  = 2'd3;

   // Mode value that marks a configuration byte after reset.
   localparam logic [MODE_W-1:0] CFG_MODE_RESET = 2'd3;

   // Result transaction, packed from the highest bit down into rsp_tdata.
   typedef struct packed {
      logic                  sequence_error;
      logic                  word_ready;
      logic [WORD_W-1:0]     word_value;
      logic [NIBBLE_W-1:0]   remote_config_index;
      logic [SLOT_W-1:0]     slot_index;
      logic [MODE_W-1:0]     link_mode;
   } rsp_payload_type;

   localparam int unsigned RSP_PAYLOAD_W = $bits(rsp_payload_type);
   localparam int unsigned RSP_DATA_W    = ((RSP_PAYLOAD_W + 7) / 8) * 8;

endpackage

`default_nettype wire

### hw/rtl/nibble_heartbeat_deframer_unit.sv
`default_nettype none

// Heartbeat byte deframer.
// Each req_ transaction carries one received status byte: mode in bits 7:6,
// slot index in bits 5:4 and a data nibble in bits 3:0. A byte whose mode
// equals the configured mode code latches its nibble as the remote
// configuration index; any other byte stores its nibble in its slot, checks
// the slot against the expected one and, on slot 3, assembles a 16-bit word
// with slot 0 in the most significant place.
// Every accepted byte produces exactly one rsp_ transaction, registered in
// the output register or the skid entry. A byte can be taken in every cycle
// while req_tready is high: all decoding and state update is one short level
// of logic between the input handshake and the result register.
// The result side has an output register plus one skid entry, so req_tready
// is a plain register output and the block keeps accepting one more byte
// into the skid entry after the receiver stops taking results; it then drops
// req_tready until the skid entry drains.
// The csr_ channel writes the configure mode code; it is always ready and
// should be written only while no transaction is in flight.
// Synchronous reset clears the nibble store, expected slot, error flag,
// assembled word and configuration index to zero, sets the mode code to 3
// and empties the result registers.
module nibble_heartbeat_deframer_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   // req_tdata: heartbeat_byte[7:0]
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [nhb_pkg::BYTE_W-1:0]            req_tdata,
   // rsp_tdata: link_mode[1:0], slot_index[3:2], remote_config_index[7:4],
   //            word_value[23:8], word_ready[24], sequence_error[25], zero[31:26]
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [nhb_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // csr_data: configure_mode_code[1:0]
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [nhb_pkg::MODE_W-1:0]            csr_data
);
   import nhb_pkg::*;

   // Deframing state.
   logic [NIBBLE_W-1:0] nibble_ff [SLOT_CNT];
   logic [NIBBLE_W-1:0] nibble_in [SLOT_CNT];
   logic [SLOT_W-1:0]   expected_slot_ff, expected_slot_in;
   logic                error_flag_ff, error_flag_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [NIBBLE_W-1:0] cfg_index_ff, cfg_index_in;
   logic [MODE_W-1:0]   cfg_mode_ff;

   // Result output register and skid entry.
   rsp_payload_type     out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     skid_ff, skid_in;
   logic                skid_valid_ff, skid_valid_in;

   logic                req_accept;
   logic                rsp_accept;
   logic [MODE_W-1:0]   byte_mode;
   logic [SLOT_W-1:0]   byte_slot;
   logic [NIBBLE_W-1:0] byte_nibble;
   logic                is_cfg_byte;
   logic                word_done;
   rsp_payload_type     result;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = out_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   assign byte_mode   = req_tdata[MODE_LSB +: MODE_W];
   assign byte_slot   = req_tdata[SLOT_LSB +: SLOT_W];
   assign byte_nibble = req_tdata[NIBBLE_W-1:0];
   assign is_cfg_byte = (byte_mode == cfg_mode_ff);

   // Next deframing state for the byte on the input.
   always_comb begin
      nibble_in        = nibble_ff;
      expected_slot_in = expected_slot_ff;
      error_flag_in    = error_flag_ff;
      word_in          = word_ff;
      cfg_index_in     = cfg_index_ff;
      word_done        = 1'b0;
      if (is_cfg_byte) begin
         cfg_index_in = byte_nibble;
      end else begin
         nibble_in[byte_slot] = byte_nibble;
         // A mismatch sets the flag; the slot then resynchronizes the
         // expected index. Slot 0 clears the flag, even after a mismatch.
         if (byte_slot != expected_slot_ff) begin
            error_flag_in = 1'b1;
         end
         if (byte_slot == LAST_SLOT) begin
            word_in          = {nibble_ff[0], nibble_ff[1], nibble_ff[2], byte_nibble};
            expected_slot_in = FIRST_SLOT;
            word_done        = 1'b1;
         end else begin
            if (byte_slot == FIRST_SLOT) begin
               error_flag_in = 1'b0;
            end
            expected_slot_in = byte_slot + 2'd1;
         end
      end
   end

   always_comb begin
      result.link_mode           = byte_mode;
      result.slot_index          = byte_slot;
      result.remote_config_index = cfg_index_in;
      result.word_value          = word_in;
      result.word_ready          = word_done;
      result.sequence_error      = error_flag_in;
   end

   // Output register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_accept) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = req_accept;
         end
      end else if (req_accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nibble_ff        <= '{default: '0};
         expected_slot_ff <= FIRST_SLOT;
         error_flag_ff    <= 1'b0;
         word_ff          <= '0;
         cfg_index_ff     <= '0;
         cfg_mode_ff      <= CFG_MODE_RESET;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            nibble_ff        <= nibble_in;
            expected_slot_ff <= expected_slot_in;
            error_flag_ff    <= error_flag_in;
            word_ff          <= word_in;
            cfg_index_ff     <= cfg_index_in;
         end
         if (csr_valid && csr_ready) begin
            cfg_mode_ff <= csr_data;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_PAYLOAD_W){1'b0}}, out_ff};

`ifndef SYNTH
   // The skid entry is only ever filled behind a held output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register is empty");

   // A data byte on slot 0 always leaves the error flag clear.
   a_slot0_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_cfg_byte && byte_slot == FIRST_SLOT) |=> !error_flag_ff)
      else $error("error flag set after a slot 0 data byte");

   // A completed word is only reported for slot 3.
   a_word_on_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.word_ready) |-> (out_ff.slot_index == LAST_SLOT))
      else $error("word_ready reported on a slot other than the last");

   // After a data byte the expected slot follows the received slot.
   a_expect_follows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_cfg_byte) |=> (expected_slot_ff == $past(byte_slot) + 2'd1))
      else $error("expected slot did not resynchronize to the received slot");
`endif

endmodule

`default_nettype wire

### test/nibble_heartbeat_deframer_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the heartbeat byte deframer. A driver and a monitor
// run as clocked always blocks; an initial block queues status bytes phase by
// phase and rewrites the configure mode code only while the block is idle.
module nibble_heartbeat_deframer_unit_tb;
   import nhb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned ITEMS_PER_PHASE = 256;
   localparam int unsigned REPORT_MAX = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [MODE_W-1:0]     csr_data = '0;

   nibble_heartbeat_deframer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Status bytes waiting for the driver, and the results predicted for every
   // byte the block has accepted, oldest first.
   logic [BYTE_W-1:0] byte_backlog[$];
   rsp_payload_type   predicted_rsp_q[$];

   // Shadow copy of the deframer state and of its mode code register.
   logic [NIBBLE_W-1:0] shadow_nibbles[SLOT_CNT];
   logic [SLOT_W-1:0]   shadow_next_slot;
   logic                shadow_error;
   logic [WORD_W-1:0]   shadow_word;
   logic [NIBBLE_W-1:0] shadow_cfg_index;
   logic [MODE_W-1:0]   shadow_mode_code;

   int unsigned mismatch_count = 0;
   int unsigned bytes_accepted = 0;
   int unsigned words_seen = 0;
   int unsigned cfg_bytes_seen = 0;
   int unsigned error_results = 0;
   int unsigned codes_used = 1;
   int unsigned cycle_count = 0;
   int unsigned send_gap = 0;
   int unsigned recv_stall = 0;
   bit          no_idle = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Most gaps are short or absent; now and then a long one. A phase may
   // switch idling off entirely to get back-to-back transactions.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Predicts the result of one accepted status byte and advances the shadow
   // state. A byte in the configure mode only touches the config index; any
   // other byte fills its slot and runs the sequence check.
   function automatic rsp_payload_type deframe_byte(input logic [BYTE_W-1:0] hb);
      rsp_payload_type     res;
      logic [MODE_W-1:0]   mode;
      logic [SLOT_W-1:0]   slot;
      logic [NIBBLE_W-1:0] nib;
      logic                done;
      mode = hb[MODE_LSB +: MODE_W];
      slot = hb[SLOT_LSB +: SLOT_W];
      nib  = hb[NIBBLE_W-1:0];
      done = 1'b0;
      if (mode != shadow_mode_code) begin
         shadow_nibbles[slot] = nib;
         if (slot != shadow_next_slot) shadow_error = 1'b1;
         if (slot == LAST_SLOT) begin
            // Slot 0 lands in the most significant nibble.
            shadow_word = {shadow_nibbles[0], shadow_nibbles[1],
                           shadow_nibbles[2], shadow_nibbles[3]};
            shadow_next_slot = FIRST_SLOT;
            done = 1'b1;
         end else begin
            // Slot 0 clears the flag even when it was itself out of order.
            if (slot == FIRST_SLOT) shadow_error = 1'b0;
            shadow_next_slot = slot + 2'd1;
         end
      end else begin
         shadow_cfg_index = nib;
      end
      res.link_mode           = mode;
      res.slot_index          = slot;
      res.remote_config_index = shadow_cfg_index;
      res.word_value          = shadow_word;
      res.word_ready          = done;
      res.sequence_error      = shadow_error;
      return res;
   endfunction

   // Driver: predicts each accepted transaction at the edge that accepts it,
   // then offers the next queued byte once its random gap has run out.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_rsp_q.push_back(deframe_byte(req_tdata));
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (byte_backlog.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_backlog.pop_front();
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result transaction against the oldest prediction
   // and stalls the result side at random.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_PAYLOAD_W-1:0];
            if (predicted_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected result transaction %h", rsp_tdata);
            end else begin
               want = predicted_rsp_q.pop_front();
               if (got.link_mode !== want.link_mode ||
                   got.slot_index !== want.slot_index ||
                   got.remote_config_index !== want.remote_config_index ||
                   got.word_value !== want.word_value ||
                   got.word_ready !== want.word_ready ||
                   got.sequence_error !== want.sequence_error ||
                   rsp_tdata[RSP_DATA_W-1:RSP_PAYLOAD_W] !== '0) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"result mismatch: expected mode %0d slot %0d cfg %h ",
                               "word %h ready %b err %b, got mode %0d slot %0d ",
                               "cfg %h word %h ready %b err %b pad %h"},
                              want.link_mode, want.slot_index,
                              want.remote_config_index, want.word_value,
                              want.word_ready, want.sequence_error,
                              got.link_mode, got.slot_index,
                              got.remote_config_index, got.word_value,
                              got.word_ready, got.sequence_error,
                              rsp_tdata[RSP_DATA_W-1:RSP_PAYLOAD_W]);
               end
               if (want.word_ready) words_seen++;
               if (want.sequence_error) error_results++;
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = pick_gap();
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("nibble_heartbeat_deframer_unit_tb: errors");
      $finish;
   end

   // Waits until the backlog is empty, nothing is being offered and every
   // predicted result has been checked, then lets the pipeline settle.
   task automatic wait_idle();
      do @(negedge clock);
      while (byte_backlog.size() != 0 || req_tvalid || predicted_rsp_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Rewrites the configure mode code over the csr channel; only called idle.
   task automatic write_mode_code(input logic [MODE_W-1:0] code);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= code;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_mode_code = code;
      codes_used++;
   endtask

   function automatic logic [MODE_W-1:0] data_mode();
      logic [MODE_W-1:0] m;
      do m = MODE_W'($urandom_range(0, 3));
      while (m == shadow_mode_code);
      return m;
   endfunction

   function automatic logic [BYTE_W-1:0] make_byte(input logic [MODE_W-1:0] m,
                                                   input logic [SLOT_W-1:0] s,
                                                   input logic [NIBBLE_W-1:0] n);
      return {m, s, n};
   endfunction

   // Queues about n bytes: mostly in-order frames with random nibbles and the
   // odd config byte mixed in, the rest broken frames and raw noise.
   task automatic queue_traffic(input int unsigned n);
      int unsigned count;
      int unsigned roll;
      int unsigned len;
      logic [SLOT_W-1:0] s;
      count = 0;
      while (count < n) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            for (int k = 0; k < SLOT_CNT; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  byte_backlog.push_back(make_byte(shadow_mode_code,
                     SLOT_W'($urandom_range(0, 3)), NIBBLE_W'($urandom)));
                  count++;
               end
               byte_backlog.push_back(make_byte(data_mode(), SLOT_W'(k),
                                                NIBBLE_W'($urandom)));
               count++;
            end
         end else if (roll < 85) begin
            // Frame starting at a random slot, possibly skipping one.
            s = SLOT_W'($urandom_range(0, 3));
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               byte_backlog.push_back(make_byte(data_mode(), s, NIBBLE_W'($urandom)));
               s = s + SLOT_W'($urandom_range(0, 2));
               count++;
            end
         end else begin
            byte_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
            count++;
         end
      end
   endtask

   initial begin
      logic [MODE_W-1:0] phase_codes[4];
      phase_codes = '{2'd0, 2'd2, 2'd1, 2'd3};
      foreach (shadow_nibbles[k]) shadow_nibbles[k] = '0;
      shadow_next_slot = FIRST_SLOT;
      shadow_error     = 1'b0;
      shadow_word      = '0;
      shadow_cfg_index = '0;
      shadow_mode_code = CFG_MODE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes under the reset mode code of 3.
      byte_backlog.push_back(make_byte(2'd0, 2'd0, 4'hF));
      byte_backlog.push_back(make_byte(2'd0, 2'd1, 4'h0));
      byte_backlog.push_back(make_byte(2'd1, 2'd2, 4'hA));
      byte_backlog.push_back(make_byte(2'd2, 2'd3, 4'h5)); // full word
      byte_backlog.push_back(8'hFF);                        // config byte, index F
      byte_backlog.push_back(8'h00);
      byte_backlog.push_back(8'hC0);                        // config byte mid frame
      byte_backlog.push_back(make_byte(2'd1, 2'd1, 4'h3));
      byte_backlog.push_back(make_byte(2'd2, 2'd3, 4'h7)); // skipped slot 2
      byte_backlog.push_back(make_byte(2'd0, 2'd2, 4'h9)); // out of order, flag set
      byte_backlog.push_back(make_byte(2'd0, 2'd3, 4'hE)); // word while flagged
      byte_backlog.push_back(make_byte(2'd0, 2'd1, 4'h1)); // flag still set
      byte_backlog.push_back(make_byte(2'd1, 2'd0, 4'h6)); // slot 0 mismatch clears
      byte_backlog.push_back(make_byte(2'd1, 2'd0, 4'h8)); // repeated slot 0
      byte_backlog.push_back(make_byte(2'd2, 2'd1, 4'hC));
      byte_backlog.push_back(8'hE5);                        // config, slot 2 field
      byte_backlog.push_back(make_byte(2'd2, 2'd2, 4'hD));
      byte_backlog.push_back(make_byte(2'd0, 2'd3, 4'hB));
      byte_backlog.push_back(8'h3F);
      byte_backlog.push_back(8'h7F);
      byte_backlog.push_back(8'hBF);
      wait_idle();

      // One phase per mode code; each phase pauses halfway until every
      // result is back before sending the rest.
      foreach (phase_codes[p]) begin
         write_mode_code(phase_codes[p]);
         no_idle = (p == 2);
         queue_traffic(ITEMS_PER_PHASE / 2);
         wait_idle();
         queue_traffic(ITEMS_PER_PHASE / 2);
         wait_idle();
      end
      no_idle = 1'b0;

      $display("covered %0d status bytes across %0d mode code settings", bytes_accepted,
               codes_used);
      $display("  %0d words assembled, %0d results with the sequence error flag",
               words_seen, error_results);
      if (mismatch_count == 0 && predicted_rsp_q.size() == 0) begin
         $display("nibble_heartbeat_deframer_unit_tb: clean");
      end else begin
         $display("nibble_heartbeat_deframer_unit_tb: errors");
      end
      $finish;
   end

endmodule
